// ----- sv/pwalk_pkg.sv -----
package pwalk_pkg;

   localparam int VA_W     = 48;
   localparam int PA_W     = 52;
   localparam int WORD_W   = 64;
   localparam int FLAGS_W  = 12;
   localparam int IDX_W    = 9;
   localparam int FRAME_W  = 40;
   localparam int STATUS_W = 2;
   localparam int SIZE_W   = 2;
   localparam int LEVEL_W  = 2;

   localparam logic CMD_WRITE     = 1'b0;
   localparam logic CMD_TRANSLATE = 1'b1;

   localparam logic [STATUS_W-1:0] STATUS_OK          = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_NOT_PRESENT = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_HUGE_TOP    = 2'd2;

   localparam logic [SIZE_W-1:0] SIZE_4K = 2'd0;
   localparam logic [SIZE_W-1:0] SIZE_2M = 2'd1;
   localparam logic [SIZE_W-1:0] SIZE_1G = 2'd2;

   localparam logic [LEVEL_W-1:0] LEVEL_PML4 = 2'd0;
   localparam logic [LEVEL_W-1:0] LEVEL_PDPT = 2'd1;
   localparam logic [LEVEL_W-1:0] LEVEL_PD   = 2'd2;
   localparam logic [LEVEL_W-1:0] LEVEL_PT   = 2'd3;

   localparam int BIT_PRESENT = 0;
   localparam int BIT_HUGE    = 7;
   localparam int BIT_NX      = 63;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [PA_W-1:0]     phys_addr;
      logic [SIZE_W-1:0]   page_size;
      logic [FLAGS_W-1:0]  leaf_flags;
      logic                no_execute;
   } result_type;

endpackage

// ----- sv/pwalk_req_if.sv -----
interface pwalk_req_if;
   logic                          valid;
   logic                          ready;
   logic                          cmd;
   logic [pwalk_pkg::VA_W-1:0]    address;
   logic [pwalk_pkg::WORD_W-1:0]  entry_word;

   modport source (output valid, output cmd, output address, output entry_word, input ready);
   modport sink (input valid, input cmd, input address, input entry_word, output ready);
endinterface

// ----- sv/pwalk_rsp_if.sv -----
interface pwalk_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [pwalk_pkg::STATUS_W-1:0]  status;
   logic [pwalk_pkg::PA_W-1:0]      phys_addr;
   logic [pwalk_pkg::SIZE_W-1:0]    page_size;
   logic [pwalk_pkg::FLAGS_W-1:0]   leaf_flags;
   logic                            no_execute;

   modport source (output valid, output status, output phys_addr, output page_size,
                   output leaf_flags, output no_execute, input ready);
   modport sink (input valid, input status, input phys_addr, input page_size,
                 input leaf_flags, input no_execute, output ready);
endinterface

// ----- sv/pwalk_ram.sv -----
module pwalk_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- sv/four_level_page_table_walker.sv -----
// Four-level page table walker with a private table memory of TABLE_WORDS 64-bit words.
// After reset the block clears the memory, one word a cycle, and accepts no item
// meanwhile; the root table base register can be written at any time through the APB
// port at byte address 0. A write item stores one word if its address is in the table.
// A translate item issues the top-level read on accept, then checks one entry per level
// visited and reads the next, as each table read depends on the previous entry and all
// reads use the single read port of the table memory. One item is in flight at a time;
// the result register lets the next item be accepted while a result waits to be taken.
module four_level_page_table_walker #(
   parameter int TABLE_WORDS = 4096
) (
   input  logic                           clock,
   input  logic                           reset,
   pwalk_req_if.sink                      req_chan,
   pwalk_rsp_if.source                    rsp_chan,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [3:0]                     paddr,
   input  logic [63:0]                    pwdata,
   output logic [63:0]                    prdata,
   output logic                           pready
);

   localparam int AW    = $clog2(TABLE_WORDS);
   localparam int WA_W  = pwalk_pkg::FRAME_W + pwalk_pkg::IDX_W;

   localparam logic [1:0] ST_CLEAR = 2'd0;
   localparam logic [1:0] ST_IDLE  = 2'd1;
   localparam logic [1:0] ST_CHECK = 2'd2;
   localparam logic [1:0] ST_DONE  = 2'd3;

   localparam logic [WA_W-1:0]                 WORDS_WA  = WA_W'(TABLE_WORDS);
   localparam logic [pwalk_pkg::VA_W-1:0]      WORDS_VA  = pwalk_pkg::VA_W'(TABLE_WORDS);
   localparam logic [AW-1:0]                   CLR_LAST  = AW'(TABLE_WORDS - 1);

   logic [1:0]                           state_ff, state_in;
   logic [AW-1:0]                        clr_ff, clr_in;
   logic [pwalk_pkg::LEVEL_W-1:0]        level_ff, level_in;
   logic [38:0]                          va_ff, va_in;
   logic                                 oob_ff, oob_in;
   logic [pwalk_pkg::PA_W-1:0]           root_ff, root_in;
   logic                                 rsp_valid_ff, rsp_valid_in;
   pwalk_pkg::result_type                rsp_ff, rsp_in;
   pwalk_pkg::result_type                res_ff, res_in;

   logic                                 accept;
   logic                                 slot_free;
   logic                                 fin;
   pwalk_pkg::result_type                fin_res;
   logic [pwalk_pkg::WORD_W-1:0]         entry;
   logic [pwalk_pkg::FRAME_W-1:0]        base;
   logic [pwalk_pkg::IDX_W-1:0]          idx;
   logic [WA_W-1:0]                      word_addr;
   logic                                 rd_en;
   logic                                 wr_en;
   logic [AW-1:0]                        wr_addr;
   logic [pwalk_pkg::WORD_W-1:0]         wr_data;
   logic [pwalk_pkg::WORD_W-1:0]         rd_data;
   logic                                 csr_write;

   pwalk_ram #(
      .WIDTH(pwalk_pkg::WORD_W),
      .DEPTH(TABLE_WORDS)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (word_addr[AW-1:0]),
      .rd_data (rd_data)
   );

   // config port
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && !paddr[3];
   assign prdata    = paddr[3] ? 64'd0 : {12'd0, root_ff};
   assign root_in   = csr_write ? pwdata[pwalk_pkg::PA_W-1:0] : root_ff;

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign accept         = req_chan.valid && req_chan.ready;
   assign slot_free      = !rsp_valid_ff || rsp_chan.ready;
   assign entry          = oob_ff ? '0 : rd_data;

   // next table word address
   always_comb begin
      if (state_ff == ST_IDLE) begin
         base = root_ff[pwalk_pkg::PA_W-1:12];
         idx  = req_chan.address[47:39];
      end else begin
         base = entry[pwalk_pkg::PA_W-1:12];
         case (level_ff)
            pwalk_pkg::LEVEL_PML4: idx = va_ff[38:30];
            pwalk_pkg::LEVEL_PDPT: idx = va_ff[29:21];
            default:               idx = va_ff[20:12];
         endcase
      end
   end

   assign word_addr = {base, idx};
   assign oob_in    = (word_addr >= WORDS_WA);

   always_comb begin
      state_in  = state_ff;
      clr_in    = clr_ff;
      level_in  = level_ff;
      va_in     = va_ff;
      fin       = 1'b0;
      fin_res   = '0;
      rd_en     = 1'b0;
      wr_en     = 1'b0;
      wr_addr   = req_chan.address[AW-1:0];
      wr_data   = req_chan.entry_word;
      case (state_ff)
         ST_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = clr_ff;
            wr_data = '0;
            clr_in  = clr_ff + AW'(1);
            if (clr_ff == CLR_LAST) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               if (req_chan.cmd == pwalk_pkg::CMD_WRITE) begin
                  wr_en = (req_chan.address < WORDS_VA);
                  fin   = 1'b1;
               end else begin
                  rd_en    = 1'b1;
                  va_in    = req_chan.address[38:0];
                  level_in = pwalk_pkg::LEVEL_PML4;
                  state_in = ST_CHECK;
               end
            end
         end
         ST_CHECK: begin
            if (!entry[pwalk_pkg::BIT_PRESENT]) begin
               fin            = 1'b1;
               fin_res.status = pwalk_pkg::STATUS_NOT_PRESENT;
            end else if (level_ff == pwalk_pkg::LEVEL_PT) begin
               fin                = 1'b1;
               fin_res.phys_addr  = {entry[pwalk_pkg::PA_W-1:12], va_ff[11:0]};
               fin_res.page_size  = pwalk_pkg::SIZE_4K;
               fin_res.leaf_flags = entry[pwalk_pkg::FLAGS_W-1:0];
               fin_res.no_execute = entry[pwalk_pkg::BIT_NX];
            end else if (entry[pwalk_pkg::BIT_HUGE]) begin
               fin = 1'b1;
               case (level_ff)
                  pwalk_pkg::LEVEL_PML4: begin
                     fin_res.status = pwalk_pkg::STATUS_HUGE_TOP;
                  end
                  pwalk_pkg::LEVEL_PDPT: begin
                     fin_res.phys_addr = {entry[pwalk_pkg::PA_W-1:30], va_ff[29:0]};
                     fin_res.page_size = pwalk_pkg::SIZE_1G;
                  end
                  default: begin
                     fin_res.phys_addr = {entry[pwalk_pkg::PA_W-1:21], va_ff[20:0]};
                     fin_res.page_size = pwalk_pkg::SIZE_2M;
                  end
               endcase
            end else begin
               rd_en    = 1'b1;
               level_in = level_ff + pwalk_pkg::LEVEL_W'(1);
            end
            if (fin) begin
               state_in = slot_free ? ST_IDLE : ST_DONE;
            end
         end
         ST_DONE: begin
            if (slot_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      if (fin && state_ff == ST_IDLE && !slot_free) begin
         state_in = ST_DONE;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_in       = rsp_ff;
      res_in       = res_ff;
      if (fin) begin
         if (slot_free) begin
            rsp_valid_in = 1'b1;
            rsp_in       = fin_res;
         end else begin
            res_in = fin_res;
         end
      end else if (state_ff == ST_DONE && slot_free) begin
         rsp_valid_in = 1'b1;
         rsp_in       = res_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         root_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
         root_ff      <= root_in;
      end
   end

   always_ff @(posedge clock) begin
      level_ff <= level_in;
      va_ff    <= va_in;
      oob_ff   <= oob_in;
      rsp_ff   <= rsp_in;
      res_ff   <= res_in;
   end

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.status     = rsp_ff.status;
   assign rsp_chan.phys_addr  = rsp_ff.phys_addr;
   assign rsp_chan.page_size  = rsp_ff.page_size;
   assign rsp_chan.leaf_flags = rsp_ff.leaf_flags;
   assign rsp_chan.no_execute = rsp_ff.no_execute;

endmodule
